@@ rtl/six_axis_force_calibration_core_assert.svh @@
// Assertion macros shared by the six-axis force calibration RTL.
// Expects signals named clk and rst in the including module's scope.
`ifndef SIX_AXIS_FORCE_CALIBRATION_CORE_ASSERT_SVH
`define SIX_AXIS_FORCE_CALIBRATION_CORE_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define SIXFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SIXFC_ASSERT_NEVER(label, cond, msg) \
  `SIXFC_ASSERT(label, !(cond), msg)

`endif

@@ rtl/sixfc_pkg.sv @@
// Shared constants, types and the calibration coefficient table of the
// six-axis force calibration core. No dependencies.
`timescale 1ns / 1ps

package sixfc_pkg;

  localparam int AXES           = 6;
  localparam int IDX_W          = $clog2(AXES);
  localparam int STEPS          = AXES * AXES;
  localparam int STEP_W         = $clog2(STEPS);
  localparam int COEF_FRAC_BITS = 16;
  localparam int VOLT_W         = 16;
  // Every coefficient magnitude stays below 64 before scaling.
  localparam int COEF_W         = COEF_FRAC_BITS + 8;
  localparam int PROD_W         = COEF_W + VOLT_W;
  localparam int ACC_W          = PROD_W + 3;
  localparam int TARE_W         = 40;
  localparam int SUM_W          = (ACC_W > TARE_W) ? ACC_W : TARE_W;
  localparam int DIFF_W         = SUM_W + 1;
  localparam int OUT_W          = 24;
  localparam int IN_DATA_W      = AXES * VOLT_W;
  localparam int OUT_DATA_W     = AXES * OUT_W;
  // Tare memory read is issued at this column so the data survives until
  // the row's sum is finished.
  localparam int READ_COL       = 3;
  localparam longint MICRO_DEN  = 1000000;

  typedef logic signed [VOLT_W-1:0] volt_vec_t [AXES];
  typedef logic signed [COEF_W-1:0] coef_tab_t [STEPS];

  // Calibration matrix in millionths, row by row.
  localparam longint CAL_MICRO [STEPS] = '{
       23820, -18445740,   -222390,  20356160,     -75587,    -85340,
       91960, -10699170,    107930, -11686870,    -173410,  23109860,
   -32267210,    -74100, -32927760,   -404650,  -34276230,   -251020,
     -921140,      2420,    953340,     11670,      28760,     -2950,
     -565200,      2090,   -570450,    -20800,    1109650,      6270,
       -2040,    690080,     -8400,    784570,      -5370,    737500
  };

  // Scale each entry to fixed point, rounding half away from zero.
  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    longint    num;
    longint    mag;
    longint    q;
    for (int k = 0; k < STEPS; k++) begin
      num = CAL_MICRO[k] * (longint'(1) <<< COEF_FRAC_BITS);
      mag = (num < 0) ? -num : num;
      q   = (mag + MICRO_DEN / 2) / MICRO_DEN;
      tab[k] = COEF_W'((num < 0) ? -q : q);
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef_tab();

  // Finished row sums and tare memory read requests, MAC to tare stage.
  typedef struct packed {
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_row;
    logic                    vld;
    logic [IDX_W-1:0]        row;
    logic                    cap;
    logic signed [ACC_W-1:0] acc;
  } mac_fin_t;

  // One rounded, saturated axis value.
  typedef struct packed {
    logic                    vld;
    logic [IDX_W-1:0]        row;
    logic                    last;
    logic signed [OUT_W-1:0] value;
  } res_t;

endpackage

@@ rtl/sixfc_mac.sv @@
// Shared multiply-accumulate unit: steps through the 36 matrix entries of
// one item, one product per cycle. Depends on sixfc_pkg.
`timescale 1ns / 1ps

module sixfc_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 start_cap,
  input  sixfc_pkg::volt_vec_t start_volt,
  output logic                 busy,
  output sixfc_pkg::mac_fin_t  fin
);

  logic                                  run;
  logic [sixfc_pkg::IDX_W-1:0]           row;
  logic [sixfc_pkg::IDX_W-1:0]           col;
  logic [sixfc_pkg::STEP_W-1:0]          k;
  logic                                  cap;
  sixfc_pkg::volt_vec_t                  volt;

  logic                                  prod_vld;
  logic                                  prod_first;
  logic                                  prod_last;
  logic [sixfc_pkg::IDX_W-1:0]           prod_row;
  logic                                  prod_cap;
  logic signed [sixfc_pkg::PROD_W-1:0]   prod;

  logic                                  fin_vld;
  logic [sixfc_pkg::IDX_W-1:0]           fin_row;
  logic                                  fin_cap;
  logic signed [sixfc_pkg::ACC_W-1:0]    acc;

  logic                                  row_end;

  assign row_end = (col == sixfc_pkg::IDX_W'(sixfc_pkg::AXES - 1));

  // Step sequencer over row and column.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && row_end && row == sixfc_pkg::IDX_W'(sixfc_pkg::AXES - 1)) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row  <= '0;
      col  <= '0;
      k    <= '0;
      cap  <= start_cap;
      volt <= start_volt;
    end else if (run) begin
      k <= k + 1'b1;
      if (row_end) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= run;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= sixfc_pkg::COEF_TAB[k] * volt[col];
    prod_first <= (col == '0);
    prod_last  <= row_end;
    prod_row   <= row;
    prod_cap   <= cap;
  end

  // Accumulate stage: restart on the first column of each row.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else begin
      fin_vld <= prod_vld && prod_last;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      acc     <= prod_first ? sixfc_pkg::ACC_W'(prod) : acc + sixfc_pkg::ACC_W'(prod);
      fin_row <= prod_row;
      fin_cap <= prod_cap;
    end
  end

  assign fin.rd_en  = run && (col == sixfc_pkg::IDX_W'(sixfc_pkg::READ_COL));
  assign fin.rd_row = row;
  assign fin.vld    = fin_vld;
  assign fin.row    = fin_row;
  assign fin.cap    = fin_cap;
  assign fin.acc    = acc;

  assign busy = run || prod_vld || fin_vld;

endmodule

@@ rtl/sixfc_tare.sv @@
// Tare memory written on capture, tare subtraction, rounding
// half away from zero and 24-bit saturation. Depends on sixfc_pkg.
`timescale 1ns / 1ps

module sixfc_tare (
  input  logic                clk,
  input  logic                rst,
  input  sixfc_pkg::mac_fin_t fin,
  output logic                busy,
  output sixfc_pkg::res_t     res
);

  localparam int RND_W = sixfc_pkg::DIFF_W + 1;
  localparam logic signed [sixfc_pkg::SUM_W-1:0] TARE_MAX =
    sixfc_pkg::SUM_W'({1'b0, {(sixfc_pkg::TARE_W-1){1'b1}}});
  localparam logic signed [sixfc_pkg::SUM_W-1:0] TARE_MIN = -TARE_MAX - 1;
  localparam logic signed [RND_W-1:0] RND_HALF =
    RND_W'(longint'(1) <<< (sixfc_pkg::COEF_FRAC_BITS - 1));
  localparam logic signed [RND_W-1:0] RND_HALF_M1 = RND_HALF - 1;
  localparam logic signed [RND_W-1:0] OUT_MAX =
    RND_W'({1'b0, {(sixfc_pkg::OUT_W-1){1'b1}}});
  localparam logic signed [RND_W-1:0] OUT_MIN = -OUT_MAX - 1;

  logic signed [sixfc_pkg::TARE_W-1:0] mem [sixfc_pkg::AXES];
  logic [sixfc_pkg::AXES-1:0]          entry_ok;
  logic signed [sixfc_pkg::TARE_W-1:0] rd_data;
  logic                                rd_ok;

  logic signed [sixfc_pkg::SUM_W-1:0]  acc_ext;
  logic signed [sixfc_pkg::SUM_W-1:0]  tare_new;
  logic signed [sixfc_pkg::SUM_W-1:0]  tare_use;

  logic                                diff_vld;
  logic [sixfc_pkg::IDX_W-1:0]         diff_row;
  logic signed [sixfc_pkg::DIFF_W-1:0] diff;

  logic signed [RND_W-1:0]             rsum;
  logic signed [RND_W-1:0]             rshift;
  logic signed [sixfc_pkg::OUT_W-1:0]  sat;

  assign acc_ext = sixfc_pkg::SUM_W'(fin.acc);

  always_comb begin
    if (acc_ext > TARE_MAX) begin
      tare_new = TARE_MAX;
    end else if (acc_ext < TARE_MIN) begin
      tare_new = TARE_MIN;
    end else begin
      tare_new = acc_ext;
    end
  end

  // A capture uses the freshly stored tare for the same item.
  assign tare_use = fin.cap ? tare_new :
                    (rd_ok ? sixfc_pkg::SUM_W'(rd_data) : '0);

  // Memory: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (fin.rd_en) begin
      rd_data <= mem[fin.rd_row];
    end
    if (fin.vld && fin.cap) begin
      mem[fin.row] <= sixfc_pkg::TARE_W'(tare_new);
    end
  end

  // Entry valid bits: an unwritten entry reads as a zero tare.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      rd_ok    <= 1'b0;
    end else begin
      if (fin.rd_en) begin
        rd_ok <= entry_ok[fin.rd_row];
      end
      if (fin.vld && fin.cap) begin
        entry_ok[fin.row] <= 1'b1;
      end
    end
  end

  // Subtract stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_vld <= 1'b0;
    end else begin
      diff_vld <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    diff     <= sixfc_pkg::DIFF_W'(acc_ext) - sixfc_pkg::DIFF_W'(tare_use);
    diff_row <= fin.row;
  end

  // Round half away from zero: add half, one less for negative values,
  // then shift arithmetically.
  assign rsum   = RND_W'(diff) + (diff[sixfc_pkg::DIFF_W-1] ? RND_HALF_M1 : RND_HALF);
  assign rshift = rsum >>> sixfc_pkg::COEF_FRAC_BITS;

  always_comb begin
    if (rshift > OUT_MAX) begin
      sat = sixfc_pkg::OUT_W'(OUT_MAX);
    end else if (rshift < OUT_MIN) begin
      sat = sixfc_pkg::OUT_W'(OUT_MIN);
    end else begin
      sat = sixfc_pkg::OUT_W'(rshift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= diff_vld;
    end
  end

  always_ff @(posedge clk) begin
    res.row   <= diff_row;
    res.last  <= (diff_row == sixfc_pkg::IDX_W'(sixfc_pkg::AXES - 1));
    res.value <= sat;
  end

  assign busy = diff_vld || res.vld;

endmodule

@@ rtl/six_axis_force_calibration_core.sv @@
// Top level of the six-axis force/torque calibration core.
// Depends on sixfc_pkg, sixfc_mac, sixfc_tare and the assertion header.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_*: one item carries six signed 16-bit bridge voltages in
//   millivolts and a request flag in s_tuser (0 measure, 1 capture tare then
//   measure). Output channel m_*: one item per input, six signed 24-bit axis
//   values in thousandths (Fx, Fy, Fz, Tx, Ty, Tz), tared and saturated.
//   A single multiplier walks the 6x6 calibration matrix, one product per
//   cycle, so one item occupies the MAC unit for all 36 matrix entries;
//   the subtract, round and output stages follow. A new item is launched
//   only once the previous one has left the pipeline and the bank is free.
//   The tare vector lives in a six-entry memory read once per row and
//   written back on a capture request. A one-item input buffer takes the
//   next item while the current one is being computed, and the output
//   register holds a finished result while the next item is computed.
//   If the receiver stalls, a second finished result waits in the result
//   bank and the MAC holds off starting another item until the bank drains.
//   Reset clears all handshake state and marks every tare entry invalid, so
//   the tare reads as zero until the first capture; no clearing pass.
//
module six_axis_force_calibration_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // volt_0 [15:0], volt_1, volt_2, volt_3, volt_4, volt_5 [95:80]
  input  logic [sixfc_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type [0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // force_x [23:0], force_y, force_z, torque_x, torque_y, torque_z [143:120]
  output logic [sixfc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  `include "six_axis_force_calibration_core_assert.svh"

  logic                               in_full;
  logic                               in_cap;
  sixfc_pkg::volt_vec_t               in_volt;
  logic                               accept;
  logic                               start;
  logic                               mac_busy;
  logic                               tare_busy;
  sixfc_pkg::mac_fin_t                fin;
  sixfc_pkg::res_t                    res;
  logic signed [sixfc_pkg::OUT_W-1:0] bank [sixfc_pkg::AXES];
  logic                               bank_done;
  logic                               move;

  assign s_tready = !in_full;
  assign accept   = s_tvalid && s_tready;

  // Launch an item only once the pipeline is empty and the bank is free.
  assign start = in_full && !mac_busy && !tare_busy && !bank_done;

  // Output register loads a finished bank when it is empty or being drained.
  assign move = bank_done && (!m_tvalid || m_tready);

  // Input buffer: hold one item until the MAC takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (start) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cap <= s_tuser[0];
      for (int i = 0; i < sixfc_pkg::AXES; i++) begin
        in_volt[i] <= s_tdata[i*sixfc_pkg::VOLT_W +: sixfc_pkg::VOLT_W];
      end
    end
  end

  sixfc_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_cap  (in_cap),
    .start_volt (in_volt),
    .busy       (mac_busy),
    .fin        (fin)
  );

  sixfc_tare u_tare (
    .clk  (clk),
    .rst  (rst),
    .fin  (fin),
    .busy (tare_busy),
    .res  (res)
  );

  // Result bank: collect one axis per row.
  always_ff @(posedge clk) begin
    if (res.vld) begin
      bank[res.row] <= res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_done <= 1'b0;
    end else if (res.vld && res.last) begin
      bank_done <= 1'b1;
    end else if (move) begin
      bank_done <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < sixfc_pkg::AXES; i++) begin
        m_tdata[i*sixfc_pkg::OUT_W +: sixfc_pkg::OUT_W] <= bank[i];
      end
    end
  end

  // A finished bank must never be overwritten by the next item's rows.
  `SIXFC_ASSERT_NEVER(a_bank_overwrite, res.vld && bank_done, "result bank overwritten")
  // A tare read never hits the row being written back in the same cycle.
  `SIXFC_ASSERT_NEVER(a_tare_rw_clash, fin.rd_en && fin.vld && fin.cap && fin.rd_row == fin.row, "tare read/write clash")
  // The output only turns valid from a complete bank.
  `SIXFC_ASSERT(a_out_from_bank, $rose(m_tvalid) |-> $past(bank_done), "output valid without bank")

endmodule

@@ bench/tb_six_axis_force_calibration_core.sv @@
// Self-checking bench for six_axis_force_calibration_core: a stream of bridge samples
// goes in, and every result is compared axis by axis with a predictor kept in the bench.
// Depends on sixfc_pkg for widths and on the RTL of the core.
`timescale 1ns / 1ps

module tb_six_axis_force_calibration_core;

  localparam int  NUM_AXES   = sixfc_pkg::AXES;
  localparam int  MV_W       = sixfc_pkg::VOLT_W;
  localparam int  AXIS_W     = sixfc_pkg::OUT_W;
  localparam int  FRAC       = sixfc_pkg::COEF_FRAC_BITS;
  localparam int  RANDOM_N   = 1450;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_CYCLES = 120;
  localparam int  HOLD_CYCLES  = 700;

  // Request codes carried in tuser.
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_TARE    = 1'b1;

  localparam logic [MV_W-1:0] MV_MAX  = 16'h7FFF;
  localparam logic [MV_W-1:0] MV_MIN  = 16'h8000;
  localparam logic [MV_W-1:0] MV_ZERO = 16'h0000;

  localparam longint TARE_HI = (longint'(1) <<< 39) - 1;
  localparam longint TARE_LO = -(longint'(1) <<< 39);
  localparam longint AXIS_HI = (longint'(1) <<< (AXIS_W - 1)) - 1;
  localparam longint AXIS_LO = -(longint'(1) <<< (AXIS_W - 1));

  // Published calibration matrix in millionths, row by row (Fx..Tz by ch0..ch5).
  localparam longint CAL_MILLIONTHS [NUM_AXES*NUM_AXES] = '{
       23820, -18445740,   -222390,  20356160,     -75587,    -85340,
       91960, -10699170,    107930, -11686870,    -173410,  23109860,
   -32267210,    -74100, -32927760,   -404650,  -34276230,   -251020,
     -921140,      2420,    953340,     11670,      28760,     -2950,
     -565200,      2090,   -570450,    -20800,    1109650,      6270,
       -2040,    690080,     -8400,    784570,      -5370,    737500
  };

  typedef struct packed {
    logic                             capture;
    logic [sixfc_pkg::IN_DATA_W-1:0]  volts;    // ch0 in the lowest bits
  } bridge_sample_t;

  logic clk;
  logic rst = 1'b1;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [sixfc_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
  logic [0:0]                        s_tuser  = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [sixfc_pkg::OUT_DATA_W-1:0]  m_tdata;

  six_axis_force_calibration_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predictor state: fixed-point matrix and the tare captured so far.
  longint cal_fixed [NUM_AXES*NUM_AXES];
  longint tare_acc  [NUM_AXES];

  bridge_sample_t                    sample_q [$];   // samples waiting for the driver
  logic [sixfc_pkg::OUT_DATA_W-1:0]  axes_q   [$];   // predicted results, oldest first

  string axis_name [NUM_AXES] = '{"force_x", "force_y", "force_z",
                                  "torque_x", "torque_y", "torque_z"};

  int unsigned fail_count     = 0;
  int unsigned items_accepted = 0;
  int unsigned tare_requests  = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // Clock and the single reset at the start.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // Scale every published coefficient to fixed point, rounding half away from zero.
  function automatic void scale_matrix();
    longint num;
    longint mag;
    longint q;
    for (int k = 0; k < NUM_AXES*NUM_AXES; k++) begin
      num = CAL_MILLIONTHS[k] * (longint'(1) <<< FRAC);
      mag = (num < 0) ? -num : num;
      q   = (mag + 500000) / 1000000;
      cal_fixed[k] = (num < 0) ? -q : q;
    end
  endfunction

  // Work out the six tared axis values of one sample; a tare request first
  // replaces the stored tare with this sample's products.
  function automatic logic [sixfc_pkg::OUT_DATA_W-1:0] calibrate_sample(bridge_sample_t s);
    longint acc [NUM_AXES];
    longint mv;
    longint diff;
    longint mag;
    longint r;
    logic [sixfc_pkg::OUT_DATA_W-1:0] packed_axes;
    packed_axes = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc[i] = 0;
      for (int j = 0; j < NUM_AXES; j++) begin
        mv = longint'($signed(s.volts[j*MV_W +: MV_W]));
        acc[i] += cal_fixed[i*NUM_AXES + j] * mv;
      end
    end
    if (s.capture == REQ_TARE) begin
      for (int i = 0; i < NUM_AXES; i++)
        tare_acc[i] = (acc[i] > TARE_HI) ? TARE_HI : ((acc[i] < TARE_LO) ? TARE_LO : acc[i]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      diff = acc[i] - tare_acc[i];
      mag  = (diff < 0) ? -diff : diff;
      r    = (mag + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      r    = (diff < 0) ? -r : r;
      r    = (r > AXIS_HI) ? AXIS_HI : ((r < AXIS_LO) ? AXIS_LO : r);
      packed_axes[i*AXIS_W +: AXIS_W] = r[AXIS_W-1:0];
    end
    return packed_axes;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [sixfc_pkg::IN_DATA_W-1:0] pack_volts(
      logic [MV_W-1:0] c0, logic [MV_W-1:0] c1,
      logic [MV_W-1:0] c2, logic [MV_W-1:0] c3,
      logic [MV_W-1:0] c4, logic [MV_W-1:0] c5);
    return {c5, c4, c3, c2, c1, c0};
  endfunction

  task automatic queue_sample(logic cap, logic [sixfc_pkg::IN_DATA_W-1:0] volts);
    bridge_sample_t s;
    s.capture = cap;
    s.volts   = volts;
    sample_q.push_back(s);
  endtask

  // Mix full-range values with rails and small readings near zero.
  function automatic logic [MV_W-1:0] pick_volt();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0:       return MV_MAX;
        1:       return MV_MIN;
        2:       return MV_ZERO;
        default: return 16'hFFFF;
      endcase
    end else if (sel < 40) begin
      return MV_W'(int'($urandom_range(0, 600)) - 300);
    end
    return MV_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps, fed from sample_q.
  // Change the offer only when nothing is pending or the pending item was taken.
  // ---------------------------------------------------------------------------
  int unsigned    burst_left = 0;
  int unsigned    gap_left   = 0;
  bridge_sample_t next_sample;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        next_sample = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_sample.volts;
        s_tuser  <= next_sample.capture;
        if (burst_left <= 1) begin
          // Draw the next burst; a third of the time run straight into it.
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches mode with bits [10:9] of rx_cycle (always ready,
  // mostly ready, coin flip, long stall streaks). Twice in the run hold
  // ready low for a long stretch so the core fills and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      rx_cycle   <= 0;
      hold_left  <= 0;
      stall_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == 3000 || rx_cycle == 40000) begin
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_cycle[10:9])
          2'd0: m_tready <= 1'b1;
          2'd1: m_tready <= ($urandom_range(0, 3) != 0);
          2'd2: m_tready <= ($urandom_range(0, 1) == 1);
          default: begin
            if (stall_left != 0) begin
              stall_left <= stall_left - 1;
              m_tready   <= 1'b0;
            end else if ($urandom_range(0, 40) == 0) begin
              stall_left <= $urandom_range(1, 90);
              m_tready   <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction, then predict
  // for the item taken at this edge (a result always belongs to an older item).
  // ---------------------------------------------------------------------------
  logic [sixfc_pkg::OUT_DATA_W-1:0] want_axes;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen = results_seen + 1;
        if (axes_q.size() == 0) begin
          $error("result arrived with no prediction pending: m_tdata=%h", m_tdata);
          fail_count = fail_count + 1;
        end else begin
          want_axes = axes_q.pop_front();
          for (int k = 0; k < NUM_AXES; k++) begin
            if (m_tdata[k*AXIS_W +: AXIS_W] !== want_axes[k*AXIS_W +: AXIS_W]) begin
              $error("%s: expected %0d, actual %0d", axis_name[k],
                     $signed(want_axes[k*AXIS_W +: AXIS_W]),
                     $signed(m_tdata[k*AXIS_W +: AXIS_W]));
              fail_count = fail_count + 1;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        items_accepted = items_accepted + 1;
        if (s_tuser[0] == REQ_TARE)
          tare_requests = tare_requests + 1;
        axes_q.push_back(calibrate_sample('{capture: s_tuser[0], volts: s_tdata}));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions pending", cycle_count, axes_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [sixfc_pkg::IN_DATA_W-1:0] v;
    logic [MV_W-1:0]                 ch [NUM_AXES];

    for (int i = 0; i < NUM_AXES; i++)
      tare_acc[i] = 0;
    scale_matrix();

    // Directed: rails, bit patterns, unit steps around zero.
    queue_sample(REQ_MEASURE, '0);
    queue_sample(REQ_MEASURE, pack_volts(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX));
    queue_sample(REQ_MEASURE, pack_volts(MV_MIN, MV_MIN, MV_MIN, MV_MIN, MV_MIN, MV_MIN));
    queue_sample(REQ_MEASURE, {NUM_AXES{16'h5555}});
    queue_sample(REQ_MEASURE, {NUM_AXES{16'hAAAA}});
    queue_sample(REQ_MEASURE, pack_volts(16'h0001, 16'hFFFF, 16'h0001,
                                         16'hFFFF, 16'h0001, 16'hFFFF));
    // One channel at a time, alternating rails, to isolate each matrix column.
    for (int j = 0; j < NUM_AXES; j++) begin
      v = '0;
      v[j*MV_W +: MV_W] = (j % 2 == 0) ? MV_MAX : MV_MIN;
      queue_sample(REQ_MEASURE, v);
    end
    // Tare capture at one rail, then measure at the other: widest tared
    // swing, pushing toward output saturation.
    queue_sample(REQ_TARE,    {NUM_AXES{MV_MAX}});
    queue_sample(REQ_MEASURE, {NUM_AXES{MV_MIN}});
    queue_sample(REQ_MEASURE, '0);
    queue_sample(REQ_TARE,    '0);
    queue_sample(REQ_MEASURE, {NUM_AXES{MV_MAX}});
    queue_sample(REQ_TARE,    {NUM_AXES{MV_MIN}});
    queue_sample(REQ_MEASURE, {NUM_AXES{MV_MAX}});
    queue_sample(REQ_MEASURE, {NUM_AXES{16'hAAAA}});
    queue_sample(REQ_TARE,    {NUM_AXES{16'h5555}});
    queue_sample(REQ_MEASURE, {NUM_AXES{16'h5555}});
    queue_sample(REQ_TARE,    '0);

    // Random: mostly measurements, with an occasional tare capture that then
    // offsets everything after it.
    for (int n = 0; n < RANDOM_N; n++) begin
      for (int j = 0; j < NUM_AXES; j++)
        ch[j] = pick_volt();
      queue_sample(($urandom_range(0, 99) < 4) ? REQ_TARE : REQ_MEASURE,
                   pack_volts(ch[0], ch[1], ch[2], ch[3], ch[4], ch[5]));
    end

    // Wait until every sample went in and every prediction was answered;
    // sample at the falling edge so all updates of the rising edge are in.
    @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || axes_q.size() != 0)
      @(negedge clk);
    // Let the pipeline settle in case a stray result follows.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (axes_q.size() != 0) begin
      $error("%0d predictions left without a result", axes_q.size());
      fail_count = fail_count + 1;
    end

    $display("ran %0d samples (%0d tare captures), checked %0d results in %0d cycles",
             items_accepted, tare_requests, results_seen, cycle_count);
    $display("receiver held off %0d cycles twice; %0d axis mismatches",
             HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sixfc_pkg.sv
rtl/sixfc_mac.sv
rtl/sixfc_tare.sv
rtl/six_axis_force_calibration_core.sv
bench/tb_six_axis_force_calibration_core.sv
